// File: src/pdad_pkg.sv
`default_nettype none

package pdad_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned HYST_W     = 8;
    localparam int unsigned MS_W       = 32;

    localparam logic [HYST_W-1:0] CNT_MAX = '1;

    // Register values after reset.
    localparam logic [HYST_W-1:0] RST_HYSTERESIS = 8'd3;
    localparam logic [MS_W-1:0]   RST_ASSERT_DLY = 32'd5000;
    localparam logic [MS_W-1:0]   RST_REARM_OFF  = 32'd30000;
    localparam logic [MS_W-1:0]   RST_HB_INTVL   = 32'd60000;
    localparam logic              RST_INIT_PRES  = 1'b0;

    typedef enum logic [2:0] {
        REG_HYSTERESIS = 3'd0,
        REG_ASSERT_DLY = 3'd1,
        REG_REARM_OFF  = 3'd2,
        REG_HB_INTVL   = 3'd3,
        REG_INIT_PRES  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic             pin_presence;
        logic [NOW_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic changed;
        logic stable_presence;
        logic heartbeat_due;
    } t_out;

    typedef struct packed {
        logic [HYST_W-1:0] hyst_thresh;
        logic [MS_W-1:0]   assert_delay_ms;
        logic [MS_W-1:0]   rearm_off_ms;
        logic [MS_W-1:0]   beat_period_ms;
        logic              initial_presence;
    } t_cfg;

    // Pulse when initial_presence is written; the state is re-initialized.
    typedef struct packed {
        logic stb;
        logic presence;
    } t_init;

endpackage

`default_nettype wire

// File: src/presence_debounce_assert_delay.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_item  (pdad_pkg::t_in)
// out       output     o_out_valid / i_out_stall o_out_item (pdad_pkg::t_out)
// cfg       input      APB write, pready tied 1  paddr, pwdata, prdata
//
// An accepted item is held in the input register and moves on to the output register
// once the output is not stalled; one item per cycle while the output is not stalled.
// The debounce and heartbeat state update in that single step between the registers.
// The input stalls only while the input register holds an item and the output
// register holds a result that is stalled. Reset is synchronous and restores the
// register reset values and the matching initial state.
`default_nettype none

module presence_debounce_assert_delay #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  pdad_pkg::t_in                        i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output pdad_pkg::t_out                       o_out_item,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pdad_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pdad_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [pdad_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import pdad_pkg::*;

    localparam int unsigned CW = (TIME_WIDTH > NOW_W) ? TIME_WIDTH : NOW_W;

    t_cfg  cfg;
    t_init init;

    logic                  r_in_vld;
    t_in                   r_in;
    logic                  r_out_vld;
    t_out                  r_out;
    logic                  adv;
    logic [CW-1:0]         now_w;
    logic [TIME_WIDTH-1:0] now_t;
    t_out                  res;

    pdad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_init  (init)
    );

    assign adv        = r_in_vld & (!r_out_vld | !i_out_stall);
    assign o_in_stall = r_in_vld & !adv;
    assign now_w      = CW'(r_in.now_ms);
    assign now_t      = now_w[TIME_WIDTH-1:0];

    pdad_presence #(.TIME_WIDTH(TIME_WIDTH)) u_presence (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_init    (init),
        .i_adv     (adv),
        .i_pin     (r_in.pin_presence),
        .i_now     (now_t),
        .o_changed (res.changed),
        .o_stable  (res.stable_presence)
    );

    pdad_hbeat #(.TIME_WIDTH(TIME_WIDTH)) u_hbeat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_init  (init),
        .i_adv   (adv),
        .i_now   (now_t),
        .o_due   (res.heartbeat_due)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: src/pdad_regs.sv
`default_nettype none

module pdad_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pdad_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [pdad_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [pdad_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output pdad_pkg::t_cfg                           o_cfg,
    output pdad_pkg::t_init                          o_init
);
    import pdad_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hyst_thresh      <= RST_HYSTERESIS;
            r_cfg.assert_delay_ms  <= RST_ASSERT_DLY;
            r_cfg.rearm_off_ms     <= RST_REARM_OFF;
            r_cfg.beat_period_ms   <= RST_HB_INTVL;
            r_cfg.initial_presence <= RST_INIT_PRES;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HYSTERESIS: r_cfg.hyst_thresh      <= pwdata[HYST_W-1:0];
                REG_ASSERT_DLY: r_cfg.assert_delay_ms  <= pwdata[MS_W-1:0];
                REG_REARM_OFF:  r_cfg.rearm_off_ms     <= pwdata[MS_W-1:0];
                REG_HB_INTVL:   r_cfg.beat_period_ms   <= pwdata[MS_W-1:0];
                REG_INIT_PRES:  r_cfg.initial_presence <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HYSTERESIS: prdata = CFG_DATA_W'(r_cfg.hyst_thresh);
            REG_ASSERT_DLY: prdata = CFG_DATA_W'(r_cfg.assert_delay_ms);
            REG_REARM_OFF:  prdata = CFG_DATA_W'(r_cfg.rearm_off_ms);
            REG_HB_INTVL:   prdata = CFG_DATA_W'(r_cfg.beat_period_ms);
            REG_INIT_PRES:  prdata = CFG_DATA_W'(r_cfg.initial_presence);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg        = r_cfg;
    assign o_init.stb   = wr_en & (reg_idx == REG_INIT_PRES);
    assign o_init.presence = pwdata[0];

endmodule

`default_nettype wire

// File: src/pdad_presence.sv
`default_nettype none

module pdad_presence #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  pdad_pkg::t_cfg             i_cfg,
    input  pdad_pkg::t_init            i_init,
    input  wire logic                  i_adv,
    input  wire logic                  i_pin,
    input  wire logic [TIME_WIDTH-1:0] i_now,
    output logic                       o_changed,
    output logic                       o_stable
);
    import pdad_pkg::*;

    localparam int unsigned CW = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;

    logic                  r_deb, n_deb;
    logic                  r_stable, n_stable;
    logic                  r_req, n_req;
    logic                  r_armed, n_armed;
    logic [HYST_W-1:0]     r_cnt, n_cnt;
    logic [TIME_WIDTH-1:0] r_dly_start, n_dly_start;
    logic [TIME_WIDTH-1:0] r_off_start, n_off_start;

    logic [HYST_W-1:0]     cnt_inc;
    logic [TIME_WIDTH-1:0] off_el;
    logic [TIME_WIDTH-1:0] dly_el;
    logic                  dly_nz;
    logic                  rearm_hit;
    logic                  dly_hit;
    logic                  changed;

    assign dly_nz    = (i_cfg.assert_delay_ms != '0);
    assign off_el    = i_now - r_off_start;
    assign dly_el    = i_now - r_dly_start;
    assign rearm_hit = CW'(off_el) >= CW'(i_cfg.rearm_off_ms);
    assign dly_hit   = CW'(dly_el) >= CW'(i_cfg.assert_delay_ms);
    assign cnt_inc   = (r_cnt != CNT_MAX) ? r_cnt + HYST_W'(1) : r_cnt;

    always_comb begin
        n_deb       = r_deb;
        n_stable    = r_stable;
        n_req       = r_req;
        n_armed     = r_armed;
        n_cnt       = r_cnt;
        n_dly_start = r_dly_start;
        n_off_start = r_off_start;
        changed     = 1'b0;

        if (i_pin == r_deb) begin
            n_cnt = '0;
        end else if (cnt_inc >= i_cfg.hyst_thresh) begin
            n_deb = i_pin;
            n_cnt = '0;
        end else begin
            n_cnt = cnt_inc;
        end

        if (r_stable) begin
            // Losing presence drops the stable level at once.
            if (!n_deb) begin
                n_stable    = 1'b0;
                n_armed     = 1'b0;
                n_off_start = i_now;
                changed     = 1'b1;
            end
        end else if (!n_deb) begin
            n_armed = 1'b0;
            if (!r_req && dly_nz && rearm_hit) begin
                n_req = 1'b1;
            end
        end else if (!r_req || !dly_nz) begin
            n_stable    = 1'b1;
            n_off_start = '0;
            n_armed     = 1'b0;
            n_req       = 1'b0;
            changed     = 1'b1;
        end else if (!r_armed) begin
            n_armed     = 1'b1;
            n_dly_start = i_now;
        end else if (dly_hit) begin
            n_stable    = 1'b1;
            n_off_start = '0;
            n_armed     = 1'b0;
            n_req       = 1'b0;
            changed     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb       <= RST_INIT_PRES;
            r_req       <= (RST_ASSERT_DLY != '0);
            r_armed     <= RST_INIT_PRES & (RST_ASSERT_DLY != '0);
            r_stable    <= RST_INIT_PRES & (RST_ASSERT_DLY == '0);
            r_cnt       <= '0;
            r_dly_start <= '0;
            r_off_start <= '0;
        end else if (i_init.stb) begin
            r_deb       <= i_init.presence;
            r_req       <= dly_nz;
            r_armed     <= i_init.presence & dly_nz;
            r_stable    <= i_init.presence & !dly_nz;
            r_cnt       <= '0;
            r_dly_start <= '0;
            r_off_start <= '0;
        end else if (i_adv) begin
            r_deb       <= n_deb;
            r_stable    <= n_stable;
            r_req       <= n_req;
            r_armed     <= n_armed;
            r_cnt       <= n_cnt;
            r_dly_start <= n_dly_start;
            r_off_start <= n_off_start;
        end
    end

    assign o_changed = changed;
    assign o_stable  = n_stable;

endmodule

`default_nettype wire

// File: src/pdad_hbeat.sv
`default_nettype none

module pdad_hbeat #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  pdad_pkg::t_cfg             i_cfg,
    input  pdad_pkg::t_init            i_init,
    input  wire logic                  i_adv,
    input  wire logic [TIME_WIDTH-1:0] i_now,
    output logic                       o_due
);
    import pdad_pkg::*;

    localparam int unsigned CW = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;

    logic [TIME_WIDTH-1:0] r_next;
    logic [CW-1:0]         intvl_w;
    logic                  due;

    // Plain compare: once the due time wraps, every sample is due until now wraps too.
    assign due     = i_now >= r_next;
    assign intvl_w = CW'(i_cfg.beat_period_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
        end else if (i_init.stb) begin
            r_next <= '0;
        end else if (i_adv && due) begin
            r_next <= i_now + intvl_w[TIME_WIDTH-1:0];
        end
    end

    assign o_due = due;

endmodule

`default_nettype wire

// File: src/pdad_checker.sv
`default_nettype none

module pdad_checker (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     o_in_stall,
    input  wire logic     o_out_valid,
    input  wire logic     i_out_stall,
    input  pdad_pkg::t_out o_out_item,
    input  wire logic     pready
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    // The input side only backs up when the output register is full and held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // An accepted item moves from the input register to the output when the output is not held.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !(o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("config port not ready");

endmodule

bind presence_debounce_assert_delay pdad_checker u_pdad_checker (.*);

`default_nettype wire
